// File: hw/rtl/tdf_pkg.sv
// Shared constants, types and helper functions of the trigram document frequency block.
`default_nettype none

package tdf_pkg;

   // Sizes of the word buffer and of one histogram entry.
   localparam int MAX_WORD      = 128;
   localparam int COUNT_BITS    = 16;

   // Alphabet and trigram index space.
   localparam int ALPHA         = 26;
   localparam int TRI_DEPTH     = ALPHA * ALPHA * ALPHA;
   localparam int TRI_BITS      = $clog2(TRI_DEPTH);
   localparam int CODE_BITS     = 5;
   localparam int CHAR_BITS     = 8;

   // Per-word list of trigrams already counted.
   localparam int SEEN_DEPTH    = MAX_WORD - 2;
   localparam int SEEN_IDX_BITS = $clog2(SEEN_DEPTH);
   localparam int SEEN_CNT_BITS = $clog2(SEEN_DEPTH + 1);
   localparam int LETTER_BITS   = $clog2(MAX_WORD + 1);

   // Result widths and saturation limits.
   localparam int OUT_BITS      = 16;
   localparam int WORD_BITS     = 16;
   localparam int CNT_WIDE      = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0]  WORD_MAX  = {WORD_BITS{1'b1}};
   localparam logic [CNT_WIDE-1:0]   OUT_MAX   = CNT_WIDE'({OUT_BITS{1'b1}});

   // Character codes used for case folding.
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;

   // Request kinds.
   localparam logic ACTION_FEED  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic hist_read;
      logic commit;
   } tdf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_query;
      logic query_ok;
      logic makes_trigram;
      logic scan_done;
   } tdf_status_type;

   // True when the byte is a letter of either case.
   function automatic logic is_letter(input logic [CHAR_BITS-1:0] b);
      is_letter = ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
                  ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
   endfunction

   // Case-folded letter code, a=0 to z=25; meaningless for non-letters.
   function automatic logic [CODE_BITS-1:0] letter_code(input logic [CHAR_BITS-1:0] b);
      logic [CHAR_BITS-1:0] diff;
      if (b <= CHAR_UPPER_Z) begin
         diff = b - CHAR_UPPER_A;
      end else begin
         diff = b - CHAR_LOWER_A;
      end
      letter_code = diff[CODE_BITS-1:0];
   endfunction

   // Histogram address of a trigram: first*676 + second*26 + third.
   function automatic logic [TRI_BITS-1:0] trigram_index(input logic [CODE_BITS-1:0] a,
                                                         input logic [CODE_BITS-1:0] b,
                                                         input logic [CODE_BITS-1:0] c);
      trigram_index = TRI_BITS'(a) * TRI_BITS'(ALPHA * ALPHA) +
                      TRI_BITS'(b) * TRI_BITS'(ALPHA) + TRI_BITS'(c);
   endfunction

   // Limits a histogram count to the result field.
   function automatic logic [OUT_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] v);
      logic [CNT_WIDE-1:0] wide;
      wide = CNT_WIDE'(v);
      if (wide > OUT_MAX) begin
         wide = OUT_MAX;
      end
      clip_count = wide[OUT_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tdf_ctrl.sv
// Controller state machine that sequences clearing, scanning and histogram updates.
`default_nettype none

module tdf_ctrl import tdf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   output logic                rsp_valid,
   output tdf_cmd_type         cmd,
   input  wire tdf_status_type status
);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_DECODE = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_HREAD  = 7'b0010000,
      ST_COMMIT = 7'b0100000,
      ST_RESP   = 7'b1000000
   } tdf_state_type;

   tdf_state_type state_ff;
   tdf_state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_query) begin
               state_in = status.query_ok ? ST_HREAD : ST_COMMIT;
            end else begin
               state_in = status.makes_trigram ? ST_SCAN : ST_COMMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_HREAD;
            end
         end
         ST_HREAD: begin
            cmd.hist_read = 1'b1;
            state_in      = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the histogram clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshake outputs.
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

`default_nettype wire

// File: hw/rtl/tdf_datapath.sv
// Datapath with the trigram histogram, the per-word seen list and the word state.
`default_nettype none

module tdf_datapath import tdf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tdf_cmd_type          cmd,
   output tdf_status_type            status,
   input  wire logic                 req_action,
   input  wire logic [CHAR_BITS-1:0] req_char_byte,
   input  wire logic                 req_last_in_word,
   input  wire logic [CODE_BITS-1:0] req_query_first,
   input  wire logic [CODE_BITS-1:0] req_query_second,
   input  wire logic [CODE_BITS-1:0] req_query_third,
   output logic [OUT_BITS-1:0]       rsp_trigram_count,
   output logic                      rsp_counted_new,
   output logic [WORD_BITS-1:0]      rsp_words_indexed,
   output logic                      rsp_bad_char
);

   // Memories.
   logic [COUNT_BITS-1:0] hist_mem [TRI_DEPTH];
   logic [TRI_BITS-1:0]   seen_mem [SEEN_DEPTH];

   // Latched request.
   logic                 action_ff;
   logic [CHAR_BITS-1:0] char_ff;
   logic                 last_ff;
   logic                 query_ok_ff;
   logic [TRI_BITS-1:0]  trig_ff;

   // Word state.
   logic [LETTER_BITS-1:0]   letters_ff,    letters_in;
   logic [SEEN_CNT_BITS-1:0] seen_total_ff, seen_total_in;
   logic [2*CODE_BITS-1:0]   prev_ff,       prev_in;
   logic [WORD_BITS-1:0]     words_ff,      words_in;

   // Clearing pass and seen-list scan.
   logic [TRI_BITS-1:0]      clr_addr_ff;
   logic [SEEN_CNT_BITS-1:0] scan_idx_ff;
   logic                     pend_ff;
   logic                     hit_ff;
   logic [TRI_BITS-1:0]      seen_q_ff;
   logic [COUNT_BITS-1:0]    hist_q_ff;

   // Result registers.
   logic [OUT_BITS-1:0] count_ff, count_in;
   logic                fresh_ff, fresh_in;
   logic                bad_ff,   bad_in;

   // Write ports.
   logic                  hist_we;
   logic [TRI_BITS-1:0]   hist_waddr;
   logic [COUNT_BITS-1:0] hist_wdata;
   logic                  seen_we;

   logic                  letter_ok;
   logic                  makes_trigram;
   logic                  scan_rd;
   logic [CODE_BITS-1:0]  code;
   logic [COUNT_BITS-1:0] sat_count;

   // Decode of the latched character.
   assign code          = letter_code(char_ff);
   assign letter_ok     = is_letter(char_ff) && (letters_ff < LETTER_BITS'(MAX_WORD));
   assign makes_trigram = letter_ok && (letters_ff >= LETTER_BITS'(2));
   assign sat_count     = (hist_q_ff == COUNT_MAX) ? hist_q_ff : hist_q_ff + 1'b1;
   assign scan_rd       = cmd.scan && (scan_idx_ff != seen_total_ff);

   // Status to the controller.
   assign status.clear_last    = (clr_addr_ff == TRI_BITS'(TRI_DEPTH - 1));
   assign status.is_query      = (action_ff == ACTION_QUERY);
   assign status.query_ok      = query_ok_ff;
   assign status.makes_trigram = makes_trigram;
   assign status.scan_done     = (scan_idx_ff == seen_total_ff) && !pend_ff;

   // Latch the request and form its trigram address.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_action;
         char_ff     <= req_char_byte;
         last_ff     <= req_last_in_word;
         query_ok_ff <= (req_query_first < CODE_BITS'(ALPHA)) &&
                        (req_query_second < CODE_BITS'(ALPHA)) &&
                        (req_query_third < CODE_BITS'(ALPHA));
         if (req_action == ACTION_QUERY) begin
            trig_ff <= trigram_index(req_query_first, req_query_second, req_query_third);
         end else begin
            trig_ff <= trigram_index(prev_ff[2*CODE_BITS-1:CODE_BITS],
                                     prev_ff[CODE_BITS-1:0], letter_code(req_char_byte));
         end
      end
   end

   // Word state update, histogram write and result values.
   always_comb begin
      letters_in    = letters_ff;
      seen_total_in = seen_total_ff;
      prev_in       = prev_ff;
      words_in      = words_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      bad_in        = bad_ff;
      hist_we       = 1'b0;
      hist_waddr    = trig_ff;
      hist_wdata    = sat_count;
      seen_we       = 1'b0;
      if (cmd.clear) begin
         hist_we    = 1'b1;
         hist_waddr = clr_addr_ff;
         hist_wdata = '0;
      end
      if (cmd.commit) begin
         fresh_in = 1'b0;
         bad_in   = 1'b0;
         count_in = '0;
         if (action_ff == ACTION_QUERY) begin
            if (query_ok_ff) begin
               count_in = clip_count(hist_q_ff);
            end
         end else begin
            bad_in = !letter_ok;
            if (letter_ok) begin
               letters_in = letters_ff + 1'b1;
               prev_in    = {prev_ff[CODE_BITS-1:0], code};
               if (makes_trigram) begin
                  // The third letter makes the word count.
                  if ((letters_ff == LETTER_BITS'(2)) && (words_ff != WORD_MAX)) begin
                     words_in = words_ff + 1'b1;
                  end
                  if (hit_ff) begin
                     count_in = clip_count(hist_q_ff);
                  end else begin
                     fresh_in = 1'b1;
                     hist_we  = 1'b1;
                     count_in = clip_count(sat_count);
                     if (seen_total_ff < SEEN_CNT_BITS'(SEEN_DEPTH)) begin
                        seen_we       = 1'b1;
                        seen_total_in = seen_total_ff + 1'b1;
                     end
                  end
               end
            end
            // End of word, even when the character was dropped.
            if (last_ff) begin
               letters_in    = '0;
               seen_total_in = '0;
               prev_in       = '0;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         letters_ff    <= '0;
         seen_total_ff <= '0;
         prev_ff       <= '0;
         words_ff      <= '0;
         clr_addr_ff   <= '0;
         scan_idx_ff   <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
      end else begin
         letters_ff    <= letters_in;
         seen_total_ff <= seen_total_in;
         prev_ff       <= prev_in;
         words_ff      <= words_in;
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         // Seen-list scan: one read a cycle, compare on the registered data.
         if (cmd.load) begin
            scan_idx_ff <= '0;
            hit_ff      <= 1'b0;
         end else begin
            if (scan_rd) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            if (pend_ff && (seen_q_ff == trig_ff)) begin
               hit_ff <= 1'b1;
            end
         end
         pend_ff <= scan_rd;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      fresh_ff <= fresh_in;
      bad_ff   <= bad_in;
   end

   // Histogram memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (cmd.hist_read) begin
         hist_q_ff <= hist_mem[trig_ff];
      end
   end

   // Seen-list memory, appended at its fill count.
   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_total_ff[SEEN_IDX_BITS-1:0]] <= trig_ff;
      end
      if (scan_rd) begin
         seen_q_ff <= seen_mem[scan_idx_ff[SEEN_IDX_BITS-1:0]];
      end
   end

   assign rsp_trigram_count = count_ff;
   assign rsp_counted_new   = fresh_ff;
   assign rsp_words_indexed = words_ff;
   assign rsp_bad_char      = bad_ff;

endmodule

`default_nettype wire

// File: hw/rtl/trigram_document_frequency.sv
// Top level of the letter trigram document frequency counter.
//
// Requests arrive on the req_ ports and are taken at a clock edge where start
// is high and busy is low. A feed request (req_action low) carries one
// character of a word; a query request reads the count of one trigram.
// Every request gives exactly one response: rsp_valid is high for a single
// cycle with the rsp_ fields, and the receiver cannot hold it off.
// The path from acceptance to the response strobe depends on the request:
//   a query with letter codes in range reads the histogram, one out of range
//   does not; a dropped character or one of the first two letters of a word
//   goes straight to the commit; a letter that completes a trigram first
//   scans the seen list of the word, one read a cycle, and then reads the
//   histogram.
// busy stays high until the cycle after the strobe, so one request is in
// work at a time.
// After reset the histogram is cleared one entry a cycle: busy stays high
// until all 17576 entries are cleared, before the first request is taken.
`default_nettype none

module trigram_document_frequency import tdf_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_action,
   input  wire logic [CHAR_BITS-1:0] req_char_byte,
   input  wire logic                 req_last_in_word,
   input  wire logic [CODE_BITS-1:0] req_query_first,
   input  wire logic [CODE_BITS-1:0] req_query_second,
   input  wire logic [CODE_BITS-1:0] req_query_third,
   output logic                      rsp_valid,
   output logic [OUT_BITS-1:0]       rsp_trigram_count,
   output logic                      rsp_counted_new,
   output logic [WORD_BITS-1:0]      rsp_words_indexed,
   output logic                      rsp_bad_char
);

   tdf_cmd_type    cmd;
   tdf_status_type status;

   // Sequencer.
   tdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // Storage and arithmetic.
   tdf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_char_byte     (req_char_byte),
      .req_last_in_word  (req_last_in_word),
      .req_query_first   (req_query_first),
      .req_query_second  (req_query_second),
      .req_query_third   (req_query_third),
      .rsp_trigram_count (rsp_trigram_count),
      .rsp_counted_new   (rsp_counted_new),
      .rsp_words_indexed (rsp_words_indexed),
      .rsp_bad_char      (rsp_bad_char)
   );

endmodule

`default_nettype wire

// File: sim/tb_trigram_document_frequency.sv
// Self-checking testbench for the letter trigram document frequency counter.
`timescale 1ns / 100ps

module tb_trigram_document_frequency;
   import tdf_pkg::*;

   // Run limits: the hard timeout and the settle time after the last response.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 300;
   localparam longint unsigned SHOWN_MAX = (64'd1 << OUT_BITS) - 1;
   // Letters a..e form the small alphabet that makes trigrams repeat often.
   localparam int POOL_LETTERS = 5;

   typedef struct {
      logic                 action;
      logic [CHAR_BITS-1:0] char_byte;
      logic                 last_in_word;
      logic [CODE_BITS-1:0] query_first;
      logic [CODE_BITS-1:0] query_second;
      logic [CODE_BITS-1:0] query_third;
   } tdf_request_type;

   typedef struct {
      logic [OUT_BITS-1:0]  trigram_count;
      logic                 counted_new;
      logic [WORD_BITS-1:0] words_indexed;
      logic                 bad_char;
   } tdf_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_action;
   logic [CHAR_BITS-1:0] req_char_byte;
   logic                 req_last_in_word;
   logic [CODE_BITS-1:0] req_query_first;
   logic [CODE_BITS-1:0] req_query_second;
   logic [CODE_BITS-1:0] req_query_third;
   logic                 rsp_valid;
   logic [OUT_BITS-1:0]  rsp_trigram_count;
   logic                 rsp_counted_new;
   logic [WORD_BITS-1:0] rsp_words_indexed;
   logic                 rsp_bad_char;

   // Predicted block state: document counts and the word in progress.
   logic [COUNT_BITS-1:0] doc_count [TRI_DEPTH];
   int unsigned           word_trigrams [$];
   logic [9:0]            last_two_letters;
   int unsigned           word_letters;
   logic [WORD_BITS-1:0]  words_so_far;

   tdf_result_type  awaited_results [$];
   tdf_result_type  oldest_result;
   int unsigned     mismatch_count;
   int unsigned     cycle_count;
   bit              idle_enable;

   trigram_document_frequency dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_char_byte    (req_char_byte),
      .req_last_in_word (req_last_in_word),
      .req_query_first  (req_query_first),
      .req_query_second (req_query_second),
      .req_query_third  (req_query_third),
      .rsp_valid        (rsp_valid),
      .rsp_trigram_count(rsp_trigram_count),
      .rsp_counted_new  (rsp_counted_new),
      .rsp_words_indexed(rsp_words_indexed),
      .rsp_bad_char     (rsp_bad_char)
   );

   // Free-running 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard timeout in case the block stalls or a response never comes.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Letter code a=0 to z=25 with case folded, or -1 for any other byte.
   function automatic int letter_value(input logic [CHAR_BITS-1:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return int'(c - CHAR_UPPER_A);
      end
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         return int'(c - CHAR_LOWER_A);
      end
      return -1;
   endfunction

   // Applies one request to the predicted state and returns the expected response.
   function automatic tdf_result_type predict_response(input tdf_request_type r);
      tdf_result_type    res;
      int                code;
      int unsigned       trigram_idx;
      bit                repeat_in_word;
      longint unsigned   shown;
      res.trigram_count = '0;
      res.counted_new   = 1'b0;
      res.bad_char      = 1'b0;
      shown = 0;
      if (r.action == ACTION_QUERY) begin
         // Any code past z reads as zero.
         if (r.query_first < ALPHA && r.query_second < ALPHA && r.query_third < ALPHA) begin
            trigram_idx = int'(r.query_first) * ALPHA * ALPHA +
                          int'(r.query_second) * ALPHA + int'(r.query_third);
            shown = doc_count[trigram_idx];
         end
      end else begin
         code = letter_value(r.char_byte);
         if (code < 0 || word_letters >= MAX_WORD) begin
            res.bad_char = 1'b1;
         end else begin
            word_letters++;
            if (word_letters >= 3) begin
               trigram_idx = int'(last_two_letters[9:5]) * ALPHA * ALPHA +
                             int'(last_two_letters[4:0]) * ALPHA + code;
               if (word_letters == 3 && words_so_far != WORD_MAX) begin
                  words_so_far++;
               end
               // A trigram already counted for this word is not counted again.
               repeat_in_word = 1'b0;
               foreach (word_trigrams[i]) begin
                  if (word_trigrams[i] == trigram_idx) begin
                     repeat_in_word = 1'b1;
                  end
               end
               if (!repeat_in_word) begin
                  if (word_trigrams.size() < SEEN_DEPTH) begin
                     word_trigrams.push_back(trigram_idx);
                  end
                  if (doc_count[trigram_idx] != COUNT_MAX) begin
                     doc_count[trigram_idx]++;
                  end
                  res.counted_new = 1'b1;
               end
               shown = doc_count[trigram_idx];
            end
            last_two_letters = {last_two_letters[4:0], CODE_BITS'(code)};
         end
         // The word ends here even when this character was dropped.
         if (r.last_in_word) begin
            word_letters     = 0;
            last_two_letters = '0;
            word_trigrams.delete();
         end
      end
      res.trigram_count = (shown > SHOWN_MAX) ? OUT_BITS'(SHOWN_MAX) : OUT_BITS'(shown);
      res.words_indexed = words_so_far;
      return res;
   endfunction

   // Sends one request, with an optional idle burst first, and records its prediction.
   task automatic send_request(input tdf_request_type r);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_action       = r.action;
      req_char_byte    = r.char_byte;
      req_last_in_word = r.last_in_word;
      req_query_first  = r.query_first;
      req_query_second = r.query_second;
      req_query_third  = r.query_third;
      start            = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_results.push_back(predict_response(r));
   endtask

   // Feeds one character; the query fields carry random values that must be ignored.
   task automatic feed_char(input logic [CHAR_BITS-1:0] c, input logic last);
      tdf_request_type r;
      r.action       = ACTION_FEED;
      r.char_byte    = c;
      r.last_in_word = last;
      r.query_first  = CODE_BITS'($urandom_range(0, 31));
      r.query_second = CODE_BITS'($urandom_range(0, 31));
      r.query_third  = CODE_BITS'($urandom_range(0, 31));
      send_request(r);
   endtask

   // Queries one trigram; the character fields carry random values that must be ignored.
   task automatic query_trigram(input int unsigned a, input int unsigned b, input int unsigned c);
      tdf_request_type r;
      r.action       = ACTION_QUERY;
      r.char_byte    = CHAR_BITS'($urandom_range(0, 255));
      r.last_in_word = 1'($urandom_range(0, 1));
      r.query_first  = CODE_BITS'(a);
      r.query_second = CODE_BITS'(b);
      r.query_third  = CODE_BITS'(c);
      send_request(r);
   endtask

   // Random letter of either case, mostly from the small alphabet.
   function automatic logic [CHAR_BITS-1:0] random_letter();
      int unsigned code;
      code = ($urandom_range(0, 2) != 0) ? $urandom_range(0, POOL_LETTERS - 1)
                                         : $urandom_range(0, ALPHA - 1);
      if ($urandom_range(0, 1) == 1) begin
         return CHAR_UPPER_A + CHAR_BITS'(code);
      end
      return CHAR_LOWER_A + CHAR_BITS'(code);
   endfunction

   // Random query code: mostly the small alphabet, sometimes past z.
   function automatic int unsigned random_query_code();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         return $urandom_range(0, POOL_LETTERS - 1);
      end else if (pick < 9) begin
         return $urandom_range(0, ALPHA - 1);
      end
      return $urandom_range(0, 31);
   endfunction

   // Queries on the cleared histogram, at the corners and past z in each position.
   task automatic test_query_extremes();
      query_trigram(0, 0, 0);
      query_trigram(25, 25, 25);
      query_trigram(31, 31, 31);
      query_trigram(26, 1, 2);
      query_trigram(0, 26, 2);
      query_trigram(0, 1, 31);
   endtask

   // Short words for case folding, repeats in a word, dropped bytes and short words.
   task automatic test_word_rules();
      // Mixed case word whose last trigram repeats an earlier one.
      feed_char("A", 1'b0);
      feed_char("b", 1'b0);
      feed_char("C", 1'b0);
      feed_char("a", 1'b0);
      feed_char("b", 1'b0);
      feed_char("c", 1'b1);
      // Bytes next to the letter ranges are dropped and the letters join up.
      feed_char("x", 1'b0);
      feed_char(8'h40, 1'b0);
      feed_char("y", 1'b0);
      feed_char(8'h5B, 1'b0);
      feed_char(8'h60, 1'b0);
      feed_char("Z", 1'b1);
      // Two-letter word is never counted.
      feed_char("q", 1'b0);
      feed_char("r", 1'b1);
      // Word that ends on a dropped byte, then an empty word of extremes.
      feed_char("a", 1'b0);
      feed_char(8'h7B, 1'b1);
      feed_char(8'h00, 1'b0);
      feed_char(8'hFF, 1'b1);
      // Same trigram in a second word raises its count.
      feed_char("a", 1'b0);
      feed_char("B", 1'b0);
      feed_char("c", 1'b1);
      query_trigram(0, 1, 2);
      query_trigram(23, 24, 25);
   endtask

   // Words that fill the seen list and run past the word bound.
   task automatic test_word_bound();
      int unsigned k;
      for (k = 1; k <= MAX_WORD + 2; k++) begin
         feed_char(CHAR_LOWER_A + CHAR_BITS'($urandom_range(0, ALPHA - 1)), k == MAX_WORD + 2);
      end
      // One repeated letter gives one trigram that is counted only once.
      for (k = 1; k <= MAX_WORD + 1; k++) begin
         feed_char("m", k == MAX_WORD + 1);
      end
      query_trigram(12, 12, 12);
   endtask

   // Random text: mostly words over a small alphabet, with noise bytes and queries.
   task automatic test_random_text(input int unsigned item_total, input bit allow_idle);
      int unsigned sent;
      int unsigned word_len;
      int unsigned pick;
      int unsigned k;
      logic [CHAR_BITS-1:0] c;
      idle_enable = allow_idle;
      sent = 0;
      while (sent < item_total) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            word_len = $urandom_range(1, 8);
         end else if (pick < 97) begin
            word_len = $urandom_range(9, 40);
         end else begin
            word_len = $urandom_range(MAX_WORD - 4, MAX_WORD + 3);
         end
         for (k = 1; k <= word_len; k++) begin
            if ($urandom_range(0, 5) == 0) begin
               query_trigram(random_query_code(), random_query_code(), random_query_code());
               sent++;
            end
            c = ($urandom_range(0, 13) == 0) ? CHAR_BITS'($urandom_range(0, 255))
                                             : random_letter();
            feed_char(c, k == word_len);
            sent++;
         end
      end
   endtask

   // Compares every response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("response with no request outstanding: count %0d", rsp_trigram_count);
            mismatch_count++;
         end else begin
            oldest_result = awaited_results.pop_front();
            if (rsp_trigram_count !== oldest_result.trigram_count) begin
               $error("rsp_trigram_count expected %0d actual %0d",
                      oldest_result.trigram_count, rsp_trigram_count);
               mismatch_count++;
            end
            if (rsp_counted_new !== oldest_result.counted_new) begin
               $error("rsp_counted_new expected %0d actual %0d",
                      oldest_result.counted_new, rsp_counted_new);
               mismatch_count++;
            end
            if (rsp_words_indexed !== oldest_result.words_indexed) begin
               $error("rsp_words_indexed expected %0d actual %0d",
                      oldest_result.words_indexed, rsp_words_indexed);
               mismatch_count++;
            end
            if (rsp_bad_char !== oldest_result.bad_char) begin
               $error("rsp_bad_char expected %0d actual %0d",
                      oldest_result.bad_char, rsp_bad_char);
               mismatch_count++;
            end
         end
      end
   end

   // Reset, the test sequence, then drain and report.
   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_action       = ACTION_FEED;
      req_char_byte    = '0;
      req_last_in_word = 1'b0;
      req_query_first  = '0;
      req_query_second = '0;
      req_query_third  = '0;
      mismatch_count   = 0;
      idle_enable      = 1'b1;
      word_letters     = 0;
      last_two_letters = '0;
      words_so_far     = '0;
      foreach (doc_count[i]) begin
         doc_count[i] = '0;
      end
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_query_extremes();
      test_word_rules();
      test_word_bound();
      test_random_text(830, 1'b1);
      test_random_text(230, 1'b0);

      @(negedge clock);
      start = 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
